[rtl/core/blmt_pkg.sv]
// ----------------------------------------------------------------------------
// blmt_pkg
// Shared types, codes and constants of the blocklist membership tables.
// ----------------------------------------------------------------------------
`default_nettype none

package blmt_pkg;

    localparam int ADDR_BUCKETS_DEF = 256;
    localparam int ADDR_WAYS_DEF    = 4;
    localparam int PORT_BUCKETS_DEF = 256;
    localparam int PORT_WAYS_DEF    = 4;

    localparam int ADDR_KEY_W = 32;
    localparam int PORT_KEY_W = 24;

    // register stages of the bucket hash unit
    localparam int HASH_LAT = 3;

    localparam logic [31:0] HASH_MUL_PORT  = 32'd2654435761;
    localparam logic [31:0] HASH_MUL_PROTO = 32'd2246822519;

    localparam logic [2:0] REQ_BLOCK_IP    = 3'd0;
    localparam logic [2:0] REQ_BLOCK_PORT  = 3'd1;
    localparam logic [2:0] REQ_BLOCK_PROTO = 3'd2;
    localparam logic [2:0] REQ_QUERY_IP    = 3'd3;
    localparam logic [2:0] REQ_QUERY_PORT  = 3'd4;
    localparam logic [2:0] REQ_QUERY_PROTO = 3'd5;
    localparam logic [2:0] REQ_CLEAR_ALL   = 3'd6;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_REFUSED = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    typedef struct packed {
        logic rd;
        logic ins;
        logic clr;
    } tbl_ctrl_t;

    typedef struct packed {
        logic hit;
        logic full;
    } tbl_stat_t;

endpackage

`default_nettype wire

[rtl/core/blmt_bucket_hash.sv]
// ----------------------------------------------------------------------------
// blmt_bucket_hash
// Three-stage reduction of a 32-bit hash value modulo the bucket count.
// ----------------------------------------------------------------------------
`default_nettype none

module blmt_bucket_hash
    import blmt_pkg::*;
#(
    parameter int BUCKETS = ADDR_BUCKETS_DEF,
    localparam int IDX_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
)
(
    input  wire logic                  clk,
    input  wire logic [31:0]           x,
    output logic [IDX_W-1:0]           idx
);

    localparam logic [32:0] RECIP = 33'(64'h1_0000_0000 / BUCKETS);
    localparam logic [17:0] DIV   = 18'(BUCKETS);

    logic [64:0]      prod;
    logic [49:0]      qd;
    logic [31:0]      rem_raw;
    logic [17:0]      rem_fix;
    logic [31:0]      q_reg;
    logic [31:0]      x_reg;
    logic [17:0]      rem_reg;
    logic [IDX_W-1:0] idx_reg;

    // quotient estimate is low by at most one
    assign prod    = 65'(x) * 65'(RECIP);
    assign qd      = 50'(q_reg) * 50'(DIV);
    assign rem_raw = x_reg - qd[31:0];
    assign rem_fix = (rem_reg >= DIV) ? (rem_reg - DIV) : rem_reg;

    always_ff @(posedge clk)
    begin
        q_reg   <= prod[63:32];
        x_reg   <= x;
        rem_reg <= rem_raw[17:0];
        idx_reg <= rem_fix[IDX_W-1:0];
    end

    assign idx = idx_reg;

endmodule

`default_nettype wire

[rtl/core/blmt_bucket_table.sv]
// ----------------------------------------------------------------------------
// blmt_bucket_table
// Set-associative key store: one bucket row per memory word, with way search
// and read-modify-write insert into the lowest free way.
// ----------------------------------------------------------------------------
`default_nettype none

module blmt_bucket_table
    import blmt_pkg::*;
#(
    parameter int KEY_W   = ADDR_KEY_W,
    parameter int BUCKETS = ADDR_BUCKETS_DEF,
    parameter int WAYS    = ADDR_WAYS_DEF,
    localparam int IDX_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
)
(
    input  wire logic             clk,
    input  wire tbl_ctrl_t        ctrl,
    input  wire logic [IDX_W-1:0] rd_idx,
    input  wire logic [IDX_W-1:0] clr_idx,
    input  wire logic [KEY_W-1:0] key,
    output tbl_stat_t             stat
);

    localparam int ROW_W = WAYS * (KEY_W + 1);

    logic [ROW_W-1:0]      mem [BUCKETS];
    logic [ROW_W-1:0]      rdata_reg;
    logic [IDX_W-1:0]      idx_reg;

    logic [WAYS-1:0]       rd_vld;
    logic [WAYS*KEY_W-1:0] rd_keys;
    logic [WAYS-1:0]       hit_vec;
    logic [WAYS-1:0]       free_vec;
    logic [WAYS-1:0]       sel;
    logic [WAYS*KEY_W-1:0] new_keys;
    logic [WAYS-1:0]       new_vld;

    // row layout: keys above, one valid bit per way below
    assign rd_vld   = rdata_reg[WAYS-1:0];
    assign rd_keys  = rdata_reg[ROW_W-1:WAYS];
    assign free_vec = ~rd_vld;
    assign sel      = free_vec & (~free_vec + WAYS'(1));
    assign new_vld  = rd_vld | sel;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            hit_vec[w] = rd_vld[w] && (rd_keys[w*KEY_W +: KEY_W] == key);
            new_keys[w*KEY_W +: KEY_W] = sel[w] ? key : rd_keys[w*KEY_W +: KEY_W];
        end
    end

    assign stat.hit  = |hit_vec;
    assign stat.full = &rd_vld;

    always_ff @(posedge clk)
    begin
        if (ctrl.rd)
        begin
            rdata_reg <= mem[rd_idx];
            idx_reg   <= rd_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.clr)
        begin
            mem[clr_idx] <= '0;
        end
        else if (ctrl.ins)
        begin
            mem[idx_reg] <= {new_keys, new_vld};
        end
    end

endmodule

`default_nettype wire

[rtl/core/blocklist_membership_tables_core.sv]
// ----------------------------------------------------------------------------
// blocklist_membership_tables_core
// Address, port/protocol and protocol blocklist sets with insert, query and
// clear-all requests.
// ----------------------------------------------------------------------------
// Usage: a request (req_type, ip_addr, port_num, proto_id) is taken on the
// in channel when in_valid and in_ready are both high; exactly one response
// (status, is_blocked) follows on the out channel, in request order.
// Steps: a lookup request passes through the bucket hash reduction pipeline,
// the bucket row read, and the compare and write-back step. in_ready rises
// together with the response, so a new request is taken only after the
// response of the previous one is raised.
// Clear all sweeps the bucket memories one row a cycle; its response comes
// from the compare step after the last row is cleared.
// Reset: the same sweep runs after rst_n is released; in_ready stays low until
// the sweep ends. The protocol bitmap clears at once.
// Stall: the response sits in an output register, so a new request is taken
// while out_ready is low; that next request waits in its compare step until
// the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module blocklist_membership_tables_core
    import blmt_pkg::*;
#(
    parameter int ADDR_BUCKETS = ADDR_BUCKETS_DEF,
    parameter int ADDR_WAYS    = ADDR_WAYS_DEF,
    parameter int PORT_BUCKETS = PORT_BUCKETS_DEF,
    parameter int PORT_WAYS    = PORT_WAYS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  req_type,
    input  wire logic [31:0] ip_addr,
    input  wire logic [15:0] port_num,
    input  wire logic [7:0]  proto_id,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic             is_blocked
);

    localparam int AI_W     = (ADDR_BUCKETS > 1) ? $clog2(ADDR_BUCKETS) : 1;
    localparam int PI_W     = (PORT_BUCKETS > 1) ? $clog2(PORT_BUCKETS) : 1;
    localparam int CLR_ROWS = (ADDR_BUCKETS > PORT_BUCKETS) ? ADDR_BUCKETS : PORT_BUCKETS;
    localparam int CLR_W    = (CLR_ROWS > 1) ? $clog2(CLR_ROWS) : 1;
    localparam logic [CLR_W-1:0] CLR_LAST  = CLR_W'(CLR_ROWS - 1);
    localparam logic [1:0]       HASH_LAST = 2'(HASH_LAT - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_HASH   = 3'd1;
    localparam logic [2:0] ST_LOOKUP = 3'd2;
    localparam logic [2:0] ST_EVAL   = 3'd3;
    localparam logic [2:0] ST_CLEAR  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       hash_cnt_reg, hash_cnt_next;
    logic [CLR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             clr_resp_reg, clr_resp_next;
    logic             out_valid_reg;
    logic [255:0]     proto_map_reg;

    logic [2:0]       req_reg;
    logic [31:0]      ip_reg;
    logic [15:0]      port_reg;
    logic [7:0]       proto_reg;
    logic [31:0]      mix_a_reg;
    logic [31:0]      mix_b_reg;
    logic [1:0]       status_reg;
    logic             blocked_reg;

    logic [47:0]      mix_a;
    logic [39:0]      mix_b;
    logic             in_acc;
    logic             clear_start;
    logic             out_free;
    logic             eval_go;
    logic             port_proto_ok;
    logic             proto_ok;
    logic             proto_hit;
    logic [1:0]       ev_status;
    logic             ev_blocked;
    logic             addr_ins;
    logic             port_ins;
    logic             proto_set;

    logic [AI_W-1:0]  addr_idx;
    logic [PI_W-1:0]  port_idx;
    tbl_ctrl_t        addr_ctrl;
    tbl_ctrl_t        port_ctrl;
    tbl_stat_t        addr_stat;
    tbl_stat_t        port_stat;

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_acc      = in_valid && in_ready;
    assign clear_start = in_acc && (req_type == REQ_CLEAR_ALL);
    assign out_free    = !out_valid_reg || out_ready;
    assign eval_go     = (state_reg == ST_EVAL) && out_free;

    assign mix_a = 48'(port_num) * 48'(HASH_MUL_PORT);
    assign mix_b = 40'(proto_id) * 40'(HASH_MUL_PROTO);

    // request capture
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_reg   <= req_type;
            ip_reg    <= ip_addr;
            port_reg  <= port_num;
            proto_reg <= proto_id;
            mix_a_reg <= mix_a[31:0];
            mix_b_reg <= mix_b[31:0];
        end
    end

    blmt_bucket_hash #(
        .BUCKETS (ADDR_BUCKETS)
    ) u_addr_hash (
        .clk (clk),
        .x   (ip_reg),
        .idx (addr_idx)
    );

    blmt_bucket_hash #(
        .BUCKETS (PORT_BUCKETS)
    ) u_port_hash (
        .clk (clk),
        .x   (mix_a_reg ^ mix_b_reg),
        .idx (port_idx)
    );

    always_comb
    begin
        addr_ctrl.rd  = (state_reg == ST_LOOKUP);
        addr_ctrl.ins = eval_go && addr_ins;
        addr_ctrl.clr = (state_reg == ST_CLEAR) && (int'(clr_cnt_reg) < ADDR_BUCKETS);
        port_ctrl.rd  = (state_reg == ST_LOOKUP);
        port_ctrl.ins = eval_go && port_ins;
        port_ctrl.clr = (state_reg == ST_CLEAR) && (int'(clr_cnt_reg) < PORT_BUCKETS);
    end

    blmt_bucket_table #(
        .KEY_W   (ADDR_KEY_W),
        .BUCKETS (ADDR_BUCKETS),
        .WAYS    (ADDR_WAYS)
    ) u_addr_table (
        .clk     (clk),
        .ctrl    (addr_ctrl),
        .rd_idx  (addr_idx),
        .clr_idx (clr_cnt_reg[AI_W-1:0]),
        .key     (ip_reg),
        .stat    (addr_stat)
    );

    blmt_bucket_table #(
        .KEY_W   (PORT_KEY_W),
        .BUCKETS (PORT_BUCKETS),
        .WAYS    (PORT_WAYS)
    ) u_port_table (
        .clk     (clk),
        .ctrl    (port_ctrl),
        .rd_idx  (port_idx),
        .clr_idx (clr_cnt_reg[PI_W-1:0]),
        .key     ({port_reg, proto_reg}),
        .stat    (port_stat)
    );

    assign port_proto_ok = (proto_reg == PROTO_TCP) || (proto_reg == PROTO_UDP);
    assign proto_ok      = port_proto_ok || (proto_reg == PROTO_ICMP);
    assign proto_hit     = proto_map_reg[proto_reg];

    always_comb
    begin
        ev_status  = STATUS_OK;
        ev_blocked = 1'b0;
        addr_ins   = 1'b0;
        port_ins   = 1'b0;
        proto_set  = 1'b0;
        unique case (req_reg)
            REQ_BLOCK_IP:
            begin
                priority if (addr_stat.hit)
                begin
                    ev_blocked = 1'b1;
                end
                else if (addr_stat.full)
                begin
                    ev_status = STATUS_FULL;
                end
                else
                begin
                    addr_ins   = 1'b1;
                    ev_blocked = 1'b1;
                end
            end
            REQ_BLOCK_PORT:
            begin
                priority if (port_stat.hit)
                begin
                    ev_blocked = 1'b1;
                end
                else if (!port_proto_ok)
                begin
                    ev_status = STATUS_REFUSED;
                end
                else if (port_stat.full)
                begin
                    ev_status = STATUS_FULL;
                end
                else
                begin
                    port_ins   = 1'b1;
                    ev_blocked = 1'b1;
                end
            end
            REQ_BLOCK_PROTO:
            begin
                priority if (proto_hit)
                begin
                    ev_blocked = 1'b1;
                end
                else if (!proto_ok)
                begin
                    ev_status = STATUS_REFUSED;
                end
                else
                begin
                    proto_set  = 1'b1;
                    ev_blocked = 1'b1;
                end
            end
            REQ_QUERY_IP:    ev_blocked = addr_stat.hit;
            REQ_QUERY_PORT:  ev_blocked = port_stat.hit;
            REQ_QUERY_PROTO: ev_blocked = proto_hit;
            REQ_CLEAR_ALL:   ev_blocked = 1'b0;
            default:         ev_blocked = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        hash_cnt_next = hash_cnt_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_resp_next = clr_resp_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (clear_start)
                begin
                    state_next    = ST_CLEAR;
                    clr_cnt_next  = '0;
                    clr_resp_next = 1'b1;
                end
                else if (in_acc)
                begin
                    state_next    = ST_HASH;
                    hash_cnt_next = '0;
                end
            end
            ST_HASH:
            begin
                if (hash_cnt_reg == HASH_LAST)
                begin
                    state_next = ST_LOOKUP;
                end
                else
                begin
                    hash_cnt_next = hash_cnt_reg + 2'd1;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    clr_resp_next = 1'b0;
                    state_next    = clr_resp_reg ? ST_EVAL : ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + CLR_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // reset starts with a clearing sweep and no response owed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            hash_cnt_reg  <= '0;
            clr_cnt_reg   <= '0;
            clr_resp_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            proto_map_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            hash_cnt_reg <= hash_cnt_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_resp_reg <= clr_resp_next;
            if (eval_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (clear_start)
            begin
                proto_map_reg <= '0;
            end
            else if (eval_go && proto_set)
            begin
                proto_map_reg[proto_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_go)
        begin
            status_reg  <= ev_status;
            blocked_reg <= ev_blocked;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign is_blocked = blocked_reg;

`ifndef SYNTH
    a_addr_ins_no_dup: assert property (@(posedge clk) disable iff (!rst_n)
        addr_ctrl.ins |-> !addr_stat.hit && !addr_stat.full)
        else $error("address insert into bucket holding key or full");

    a_port_ins_proto: assert property (@(posedge clk) disable iff (!rst_n)
        port_ctrl.ins |-> (proto_reg == PROTO_TCP) || (proto_reg == PROTO_UDP))
        else $error("port insert with refused protocol");

    a_out_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_EVAL))
        else $error("response raised outside compare step");

    a_full_not_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != STATUS_OK)) |-> !blocked_reg)
        else $error("failed request reported as blocked");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("request taken while previous one in flight");
`endif

endmodule

`default_nettype wire
